// ===== sv/bdc_pkg.sv =====
// Shared types, constants and datapath functions for the block descrambler.
package bdc_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN      = 2'd0,
        CMD_DESCRAMBLE = 2'd1,
        CMD_HASH       = 2'd2
    } cmd_t;

    localparam logic [31:0] SEED_XOR    = 32'hA5C96357;
    localparam logic [31:0] SEED_MUL_A  = 32'h85EBCA6B;
    localparam logic [31:0] SEED_MUL_B  = 32'h045D9F3B;
    localparam logic [31:0] BLK_MUL_A   = 32'hC2B2AE35;
    localparam logic [31:0] BLK_MUL_B   = 32'h119DE1F3;
    localparam logic [31:0] BLK_GOLDEN  = 32'h9E3779B9;
    localparam logic [31:0] HASH_PRIME  = 32'h01000193;
    localparam logic [31:0] BLK_OFS_A   = 32'd1;
    localparam logic [31:0] BLK_OFS_B   = 32'd7;

    // seed-only part of the block key, kept in registers
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] term_a;
        logic [31:0] term_b;
    } seed_info_t;

    function automatic logic [7:0] descramble_byte(
        input logic [7:0]  data,
        input logic [7:0]  pos,
        input logic [7:0]  low,
        input logic [31:0] key
    );
        logic [7:0] b;
        logic [7:0] k;
        b = data ^ pos ^ low;
        b = {b[2:0], b[7:3]};
        case (pos[1:0])
            2'd0:    k = key[7:0];
            2'd1:    k = key[15:8];
            2'd2:    k = key[23:16];
            default: k = key[31:24];
        endcase
        return b ^ k;
    endfunction

    function automatic logic [31:0] hash_step(
        input logic [31:0] h,
        input logic [7:0]  d
    );
        logic [31:0] x;
        logic [31:0] p;
        x = h ^ {24'd0, d};
        p = x * HASH_PRIME;
        return p ^ (p >> 7);
    endfunction

endpackage

// ===== sv/bdc_seed_mix.sv =====
// Stream seed register and the registered seed terms of the block key.
module bdc_seed_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_seed_we,
    input  logic [31:0]         stream_seed_wdata,
    output bdc_pkg::seed_info_t seed_info
);
    import bdc_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] term_a_reg;
    logic [31:0] term_b_reg;
    logic [31:0] seed_next;
    logic [31:0] term_a_next;
    logic [31:0] term_b_next;

    always_comb
    begin
        seed_next   = stream_seed_we ? stream_seed_wdata : seed_reg;
        term_a_next = seed_reg * SEED_MUL_A;
        term_b_next = (seed_reg ^ SEED_XOR) * SEED_MUL_B;
    end

    // terms are registered from the seed register, so they follow it in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            term_a_reg <= '0;
            term_b_reg <= SEED_XOR * SEED_MUL_B;
        end
        else
        begin
            seed_reg   <= seed_next;
            term_a_reg <= term_a_next;
            term_b_reg <= term_b_next;
        end
    end

    assign seed_info.seed   = seed_reg;
    assign seed_info.term_a = term_a_reg;
    assign seed_info.term_b = term_b_reg;

endmodule

// ===== sv/block_descramble_and_check.sv =====
// Block descrambler and integrity check, two-stage pipeline top level.
// Takes one word per cycle unless a held result stalls it; a result passes the input
// stage and result register. Hash loop: one constant multiply and fold. Begin words
// load the block key, low index byte, position and hash seed; descramble words
// give one output byte each; hash words give a check result on the last byte only.
// A stream seed write holds for words accepted from the next cycle on.
module block_descramble_and_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_seed_we,
    input  logic [31:0] stream_seed_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] block_index,
    input  logic [31:0] block_length,
    input  logic [7:0]  data_byte,
    input  logic [15:0] expected_check,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  out_byte,
    output logic [15:0] check_value,
    output logic        check_match
);
    import bdc_pkg::*;

    seed_info_t seed_info;

    bdc_seed_mix u_seed_mix (
        .clk               (clk),
        .rst_n             (rst_n),
        .stream_seed_we    (stream_seed_we),
        .stream_seed_wdata (stream_seed_wdata),
        .seed_info         (seed_info)
    );

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [7:0]  s1_low_reg;
    logic [31:0] s1_len_reg;
    logic [7:0]  s1_data_reg;
    logic [15:0] s1_exp_reg;
    logic        s1_last_reg;
    logic [31:0] s1_key_term_reg;
    logic [31:0] s1_gold_reg;

    // block state
    logic [31:0] block_key_reg;
    logic [7:0]  block_low_reg;
    logic [7:0]  byte_pos_reg;
    logic [31:0] hash_reg;

    // result register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_check_reg;
    logic        out_match_reg;

    logic        in_fire;
    logic        s1_produces;
    logic        s1_adv;
    logic [31:0] blk_ext;
    logic [31:0] key_term_next;
    logic [31:0] gold_next;

    logic [31:0] block_key_next;
    logic [7:0]  block_low_next;
    logic [7:0]  byte_pos_next;
    logic [31:0] hash_next;
    logic        out_valid_next;
    logic        out_kind_next;
    logic [7:0]  out_byte_next;
    logic [15:0] out_check_next;
    logic        out_match_next;
    logic [31:0] hash_stepped;
    logic [15:0] fold;

    always_comb
    begin
        blk_ext       = {16'd0, block_index};
        key_term_next = ((blk_ext + BLK_OFS_A) * BLK_MUL_A)
                      ^ ((blk_ext + BLK_OFS_B) * BLK_MUL_B);
        gold_next     = blk_ext * BLK_GOLDEN;
    end

    assign s1_produces = (s1_cmd_reg == CMD_DESCRAMBLE)
                       || ((s1_cmd_reg == CMD_HASH) && s1_last_reg);
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready || !s1_produces);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg      <= command;
            s1_low_reg      <= block_index[7:0];
            s1_len_reg      <= block_length;
            s1_data_reg     <= data_byte;
            s1_exp_reg      <= expected_check;
            s1_last_reg     <= last_byte;
            s1_key_term_reg <= key_term_next;
            s1_gold_reg     <= gold_next;
        end
    end

    always_comb
    begin
        block_key_next = block_key_reg;
        block_low_next = block_low_reg;
        byte_pos_next  = byte_pos_reg;
        hash_next      = hash_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_check_next = out_check_reg;
        out_match_next = out_match_reg;
        hash_stepped   = hash_step(hash_reg, s1_data_reg);
        fold           = hash_stepped[15:0] ^ hash_stepped[31:16];

        if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (s1_adv)
        begin
            case (s1_cmd_reg)
                CMD_BEGIN:
                begin
                    block_key_next = seed_info.term_a ^ seed_info.term_b
                                   ^ s1_key_term_reg;
                    block_low_next = s1_low_reg;
                    byte_pos_next  = '0;
                    hash_next      = seed_info.seed ^ s1_gold_reg ^ s1_len_reg;
                end
                CMD_DESCRAMBLE:
                begin
                    byte_pos_next  = byte_pos_reg + 8'd1;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_byte_next  = descramble_byte(s1_data_reg, byte_pos_reg,
                                                     block_low_reg, block_key_reg);
                    out_check_next = '0;
                    out_match_next = 1'b0;
                end
                CMD_HASH:
                begin
                    hash_next = hash_stepped;
                    if (s1_last_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = 1'b1;
                        out_byte_next  = '0;
                        out_check_next = fold;
                        out_match_next = (fold == s1_exp_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_key_reg <= '0;
            block_low_reg <= '0;
            byte_pos_reg  <= '0;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            block_key_reg <= block_key_next;
            block_low_reg <= block_low_next;
            byte_pos_reg  <= byte_pos_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_check_reg <= out_check_next;
        out_match_reg <= out_match_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign check_value = out_check_reg;
    assign check_match = out_match_reg;

    a_begin_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_cmd_reg == CMD_BEGIN) |=> byte_pos_reg == 8'd0)
        else $error("byte position not cleared on begin");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_cmd_reg == CMD_DESCRAMBLE)
        |=> byte_pos_reg == $past(byte_pos_reg) + 8'd1)
        else $error("byte position did not advance");

    a_new_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv) && $past(s1_produces))
        else $error("result appeared without a producing word");

    a_hash_held_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> hash_reg == $past(hash_reg))
        else $error("hash changed without an advancing word");

    a_stall_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && s1_valid_reg && s1_produces |-> !s1_adv)
        else $error("pending result overwritten");

endmodule

// ===== test/tb_block_descramble_and_check.sv =====
// Self-checking testbench for block_descramble_and_check: directed and random words, several seeds.
`timescale 1ns / 100ps

module tb_block_descramble_and_check;
    import bdc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]  command;
        logic [15:0] block_index;
        logic [31:0] block_length;
        logic [7:0]  data_byte;
        logic [15:0] expected_check;
        logic        last_byte;
    } word_t;

    typedef struct {
        logic        kind;
        logic [7:0]  out_byte;
        logic [15:0] check_value;
        logic        check_match;
    } result_t;

    typedef struct {
        logic [31:0] seed;
        logic [31:0] key;
        logic [7:0]  low;
        logic [7:0]  pos;
        logic [31:0] hash;
    } block_state_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        stream_seed_we = 1'b0;
    logic [31:0] stream_seed_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [15:0] block_index = '0;
    logic [31:0] block_length = '0;
    logic [7:0]  data_byte = '0;
    logic [15:0] expected_check = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  out_byte;
    logic [15:0] check_value;
    logic        check_match;

    word_t        words_to_send[$];
    result_t      due_results[$];
    word_t        cur_word;
    result_t      predicted;
    result_t      want;
    block_state_t sent_state = '{default: '0};   // tracks words as accepted
    block_state_t gen_state = '{default: '0};    // tracks words as generated
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           drain_hold = 1'b0;
    int           words_accepted = 0;
    int           bytes_seen = 0;
    int           checks_seen = 0;
    int           checks_matched = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    block_descramble_and_check u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .stream_seed_we    (stream_seed_we),
        .stream_seed_wdata (stream_seed_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .block_index       (block_index),
        .block_length      (block_length),
        .data_byte         (data_byte),
        .expected_check    (expected_check),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .out_byte          (out_byte),
        .check_value       (check_value),
        .check_match       (check_match)
    );

    // Applies one word to the block state; returns 1 when the word yields a result.
    function automatic bit advance_block_state(inout block_state_t s, input word_t w,
                                               output result_t r);
        logic [31:0] idx;
        logic [7:0]  b;
        logic [31:0] h;
        logic [15:0] chk;
        idx = {16'd0, w.block_index};
        r = '{default: '0};
        case (w.command)
            CMD_BEGIN:
            begin
                s.key = (s.seed * SEED_MUL_A) ^ ((idx + BLK_OFS_A) * BLK_MUL_A)
                      ^ ((s.seed ^ SEED_XOR) * SEED_MUL_B) ^ ((idx + BLK_OFS_B) * BLK_MUL_B);
                s.low = w.block_index[7:0];
                s.pos = 8'd0;
                s.hash = s.seed ^ (idx * BLK_GOLDEN) ^ w.block_length;
                return 1'b0;
            end
            CMD_DESCRAMBLE:
            begin
                b = w.data_byte ^ s.pos ^ s.low;
                b = (b >> 3) | (b << 5);
                r.kind = 1'b0;
                r.out_byte = b ^ s.key[s.pos[1:0] * 8 +: 8];
                s.pos = s.pos + 8'd1;
                return 1'b1;
            end
            CMD_HASH:
            begin
                h = (s.hash ^ {24'd0, w.data_byte}) * HASH_PRIME;
                h = h ^ (h >> 7);
                s.hash = h;
                if (!w.last_byte)
                    return 1'b0;
                chk = h[15:0] ^ h[31:16];
                r.kind = 1'b1;
                r.check_value = chk;
                r.check_match = (chk == w.expected_check);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic word_t make_word(logic [1:0] c, logic [15:0] idx, logic [31:0] len,
                                        logic [7:0] d, logic [15:0] chk, logic lst);
        word_t w;
        w.command = c;
        w.block_index = idx;
        w.block_length = len;
        w.data_byte = d;
        w.expected_check = chk;
        w.last_byte = lst;
        return w;
    endfunction

    // fix_check makes the stored check agree with the hash, so matches occur
    task automatic queue_word(input word_t w, input bit fix_check);
        result_t r;
        if (advance_block_state(gen_state, w, r) && r.kind && fix_check)
            w.expected_check = r.check_value;
        words_to_send.push_back(w);
    endtask

    task automatic queue_random_word();
        queue_word(make_word(2'($urandom_range(3)), 16'($urandom), $urandom, 8'($urandom),
                             16'($urandom), 1'($urandom_range(1))),
                   1'($urandom_range(1)));
    endtask

    // Mostly well-formed blocks with random content, some noise words between them.
    task automatic fill_random(input int budget, input bit with_long);
        int          made;
        int          n;
        logic [15:0] idx;
        logic [31:0] len;
        bit          long_pending;
        bit          long_run;
        made = 0;
        long_pending = with_long;
        while (made < budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                queue_random_word();
                made++;
            end
            else
            begin
                case ($urandom_range(7))
                    0:       idx = 16'h0000;
                    1:       idx = 16'hFFFF;
                    default: idx = 16'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       len = 32'd0;
                    1:       len = 32'd1;
                    2:       len = 32'hFFFF_FFFF;
                    default: len = $urandom;
                endcase
                queue_word(make_word(CMD_BEGIN, idx, len, 8'($urandom), 16'($urandom), 1'b0),
                           1'b0);
                made++;
                // at most one long run per phase, when with_long is set, so the byte position wraps
                if (long_pending)
                begin
                    n = $urandom_range(260, 300);
                    long_run = 1'b1;
                    long_pending = 1'b0;
                end
                else
                begin
                    n = $urandom_range(1, 20);
                    long_run = 1'b0;
                end
                repeat (n)
                begin
                    if (long_run || $urandom_range(99) < 60)
                        queue_word(make_word(CMD_DESCRAMBLE, 16'($urandom), $urandom,
                                             8'($urandom), 16'($urandom), 1'b0), 1'b0);
                    else
                        queue_word(make_word(CMD_HASH, 16'($urandom), $urandom,
                                             8'($urandom), 16'($urandom), 1'b0), 1'b0);
                    made++;
                end
                queue_word(make_word(CMD_HASH, 16'($urandom), $urandom, 8'($urandom),
                                     16'($urandom), 1'b1),
                           $urandom_range(3) != 0);
                made++;
                if ($urandom_range(9) == 0)
                begin
                    queue_word(make_word(CMD_HASH, 16'($urandom), $urandom, 8'($urandom),
                                         16'($urandom), 1'($urandom_range(1))), 1'b1);
                    made++;
                end
            end
        end
    endtask

    // Idle means nothing queued, nothing offered and nothing outstanding, plus pipeline slack.
    task automatic wait_drained();
        @(negedge clk);
        while (words_to_send.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        stream_seed_we <= 1'b1;
        stream_seed_wdata <= value;
        sent_state.seed = value;
        gen_state.seed = value;
        @(posedge clk);
        stream_seed_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver: offers queued words, predicts results for accepted ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (advance_block_state(sent_state, cur_word, predicted))
                    due_results.push_back(predicted);
                words_accepted++;
                if (words_accepted % 300 == 0)
                    drain_hold = 1'b1;
            end
            if (!in_valid || in_ready)
            begin
                if (drain_hold && due_results.size() == 0)
                    drain_hold = 1'b0;
                if (!drain_hold && words_to_send.size() != 0
                        && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_word = words_to_send.pop_front();
                    in_valid <= 1'b1;
                    command <= cur_word.command;
                    block_index <= cur_word.block_index;
                    block_length <= cur_word.block_length;
                    data_byte <= cur_word.data_byte;
                    expected_check <= cur_word.expected_check;
                    last_byte <= cur_word.last_byte;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d out_byte %0h check_value %0h",
                           result_kind, out_byte, check_value);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        mismatches++;
                    end
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
                        mismatches++;
                    end
                    if (check_value !== want.check_value)
                    begin
                        $error("check_value: expected %04h, got %04h", want.check_value,
                               check_value);
                        mismatches++;
                    end
                    if (check_match !== want.check_match)
                    begin
                        $error("check_match: expected %0d, got %0d", want.check_match,
                               check_match);
                        mismatches++;
                    end
                    if (want.kind)
                    begin
                        checks_seen++;
                        if (want.check_match)
                            checks_matched++;
                    end
                    else
                    begin
                        bytes_seen++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
                $display("block_descramble_and_check test failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_seed(32'h0000_0000);

        // directed: reset state, ignored marks, unused command, field extremes
        queue_word(make_word(CMD_DESCRAMBLE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'hFFFF, 1'b0),
                   1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'hFF, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'h00, 16'h0000, 1'b1), 1'b1);
        queue_word(make_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1),
                   1'b0);
        queue_word(make_word(CMD_BEGIN, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'hFF, 16'h0000, 1'b1), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'h00, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'hA5, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'h5A, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'h3C, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'h00, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'hFF, 16'hFFFF, 1'b1), 1'b0);
        // hashing keeps going after the last byte
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'h12, 16'h0000, 1'b1), 1'b1);
        queue_word(make_word(CMD_BEGIN, 16'h0000, 32'd0, 8'h00, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'h80, 16'h0000, 1'b1), 1'b0);
        queue_word(make_word(CMD_BEGIN, 16'h0001, 32'd1, 8'h00, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'h81, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_HASH, 16'h0000, 32'd0, 8'h7E, 16'h0000, 1'b1), 1'b1);
        queue_word(make_word(CMD_UNUSED, 16'h0000, 32'd0, 8'h00, 16'h0000, 1'b0), 1'b0);
        queue_word(make_word(CMD_DESCRAMBLE, 16'h0000, 32'd0, 8'h18, 16'h0000, 1'b0), 1'b0);
        wait_drained();

        write_seed(32'hFFFF_FFFF);
        fill_random(420, 1'b1);
        wait_drained();

        // this seed zeroes one of the key terms
        write_seed(SEED_XOR);
        send_idle_pct = 58;
        fill_random(420, 1'b0);
        wait_drained();

        write_seed($urandom);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        fill_random(420, 1'b1);
        wait_drained();

        write_seed($urandom);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        fill_random(420, 1'b0);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("ran %0d words under five seeds and four idle patterns", words_accepted);
        $display("checked %0d descrambled bytes and %0d block checks (%0d matching)",
                 bytes_seen, checks_seen, checks_matched);
        if (mismatches == 0 && due_results.size() == 0)
            $display("block_descramble_and_check test passed");
        else
            $display("block_descramble_and_check test failed");
        $finish;
    end

endmodule

// ===== block_descramble_and_check.f =====
sv/bdc_pkg.sv
sv/bdc_seed_mix.sv
sv/block_descramble_and_check.sv
test/tb_block_descramble_and_check.sv
